[rtl/core/dram_open_row_access_timer_unit_assert.svh]
// Assertion helpers for the open-row access timer.
// Both sample on i_clk and are held off while i_rst_n is low.
`ifndef DRAM_OPEN_ROW_ACCESS_TIMER_UNIT_ASSERT_SVH
`define DRAM_OPEN_ROW_ACCESS_TIMER_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define DRAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define DRAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/drat_pkg.sv]
`timescale 1ns / 1ps
package drat_pkg;

    // Field widths fixed by the interface
    localparam int unsigned ADDR_W    = 20;
    localparam int unsigned OP_W      = 2;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DLY_W     = 10;
    localparam int unsigned COST_W    = 12;
    localparam int unsigned TOTAL_W   = 48;
    localparam int unsigned CFG_IDX_W = 2;

    // Request codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_DELAY = 2'd1;

    // Delay values after reset
    localparam logic [DLY_W-1:0] ROW_DLY_RESET = 10'd10;
    localparam logic [DLY_W-1:0] COL_DLY_RESET = 10'd2;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [ADDR_W-1:0]        address;
        logic signed [WORD_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_data;
        logic                     row_hit;
        logic [COST_W-1:0]        access_cycles;
        logic [TOTAL_W-1:0]       total_cycles;
    } t_out_item;

    typedef enum logic {
        BK_CLEAR,
        BK_RUN
    } t_back_state;

endpackage

[rtl/core/drat_front.sv]
`timescale 1ns / 1ps
module drat_front #(
    parameter int unsigned ROWS    = 1024,
    parameter int unsigned COLUMNS = 1024,
    parameter int unsigned ROW_W   = 10,
    parameter int unsigned IDX_W   = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  drat_pkg::t_in_item          i_in_item,
    input  logic                        i_hold,
    output logic                        o_push,
    input  logic                        i_full,
    output logic [drat_pkg::OP_W-1:0]   o_op,
    output logic [ROW_W-1:0]            o_row,
    output logic [IDX_W-1:0]            o_idx,
    output logic [drat_pkg::WORD_W-1:0] o_wdata
);
    import drat_pkg::*;

    // Address / COLUMNS by reciprocal multiply, exact over the whole address range
    localparam int unsigned ADDR_MAX = (1 << ADDR_W) - 1;
    localparam int unsigned L1       = $clog2(COLUMNS);
    localparam int unsigned SH1      = ADDR_W + L1;
    localparam int unsigned M1_W     = ADDR_W + 2;
    localparam longint unsigned M1   = ((64'd1 << SH1) / COLUMNS) + 64'd1;
    localparam int unsigned Q_MAX    = ADDR_MAX / COLUMNS;
    localparam int unsigned Q_W      = $clog2(Q_MAX + 1);
    localparam int unsigned P1_W     = (SH1 + Q_W > ADDR_W + M1_W) ? SH1 + Q_W : ADDR_W + M1_W;

    // Quotient / ROWS the same way, for the row wrap
    localparam int unsigned L2       = $clog2(ROWS);
    localparam int unsigned SH2      = Q_W + L2;
    localparam int unsigned M2_W     = Q_W + 2;
    localparam longint unsigned M2   = ((64'd1 << SH2) / ROWS) + 64'd1;
    localparam int unsigned R_MAX    = Q_MAX / ROWS;
    localparam int unsigned R_W      = (R_MAX == 0) ? 1 : $clog2(R_MAX + 1);
    localparam int unsigned P2_W     = (SH2 + R_W > Q_W + M2_W) ? SH2 + R_W : Q_W + M2_W;

    localparam longint unsigned CELLS = longint'(ROWS) * longint'(COLUMNS);

    localparam logic [M1_W-1:0]   M1_K   = M1_W'(M1);
    localparam logic [M2_W-1:0]   M2_K   = M2_W'(M2);
    localparam logic [31:0]       ROWS_K = 32'(ROWS);
    localparam logic [ADDR_W-1:0] ROWC_K = (CELLS > longint'(ADDR_MAX)) ? '0 : ADDR_W'(CELLS);

    logic              en;
    logic              accept;
    logic [P1_W-1:0]   n_s1_prod;
    logic [Q_W-1:0]    s1_quot;
    logic [P2_W-1:0]   n_s2_prod;
    logic [R_W-1:0]    s2_wrap;
    logic [Q_W-1:0]    n_s3_rowprod;
    logic [ADDR_W-1:0] n_s3_idxprod;
    logic [Q_W-1:0]    row_full;

    logic              r_s1_vld, r_s2_vld, r_s3_vld;
    logic [OP_W-1:0]   r_s1_op, r_s2_op, r_s3_op;
    logic [ADDR_W-1:0] r_s1_addr, r_s2_addr, r_s3_addr;
    logic [WORD_W-1:0] r_s1_wdata, r_s2_wdata, r_s3_wdata;
    logic [P1_W-1:0]   r_s1_prod;
    logic [P2_W-1:0]   r_s2_prod;
    logic [Q_W-1:0]    r_s2_quot, r_s3_quot;
    logic [Q_W-1:0]    r_s3_rowprod;
    logic [ADDR_W-1:0] r_s3_idxprod;

    // Advance the whole pipe unless the last stage is blocked by a full queue
    always_comb begin
        en         = !r_s3_vld || !i_full;
        o_in_stall = !en || i_hold;
        accept     = i_in_valid && !o_in_stall;
    end

    // Split the address: quotient, wrap count, and the products to subtract
    always_comb begin
        n_s1_prod    = P1_W'(i_in_item.address) * P1_W'(M1_K);
        s1_quot      = r_s1_prod[SH1 +: Q_W];
        n_s2_prod    = P2_W'(s1_quot) * P2_W'(M2_K);
        s2_wrap      = r_s2_prod[SH2 +: R_W];
        n_s3_rowprod = Q_W'(32'(s2_wrap) * ROWS_K);
        n_s3_idxprod = ADDR_W'(ADDR_W'(s2_wrap) * ROWC_K);
    end

    // Hand the classified request to the queue
    always_comb begin
        row_full = r_s3_quot - r_s3_rowprod;
        o_push   = r_s3_vld && !i_full;
        o_op     = r_s3_op;
        o_row    = ROW_W'(row_full);
        o_idx    = IDX_W'(r_s3_addr - r_s3_idxprod);
        o_wdata  = r_s3_wdata;
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_op      <= i_in_item.operation;
            r_s1_addr    <= i_in_item.address;
            r_s1_wdata   <= i_in_item.write_data;
            r_s1_prod    <= n_s1_prod;
            r_s2_op      <= r_s1_op;
            r_s2_addr    <= r_s1_addr;
            r_s2_wdata   <= r_s1_wdata;
            r_s2_quot    <= s1_quot;
            r_s2_prod    <= n_s2_prod;
            r_s3_op      <= r_s2_op;
            r_s3_addr    <= r_s2_addr;
            r_s3_wdata   <= r_s2_wdata;
            r_s3_quot    <= r_s2_quot;
            r_s3_rowprod <= n_s3_rowprod;
            r_s3_idxprod <= n_s3_idxprod;
        end
    end

endmodule

[rtl/core/drat_fifo.sv]
`timescale 1ns / 1ps
module drat_fifo #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and occupancy updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        o_full  = (r_count == FULLC);
        o_empty = (r_count == '0);
        o_data  = r_slot[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/drat_back.sv]
`timescale 1ns / 1ps
module drat_back #(
    parameter int unsigned ROW_W      = 10,
    parameter int unsigned IDX_W      = 20,
    parameter int unsigned DEPTH      = 1048576,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  logic [drat_pkg::OP_W-1:0]      i_op,
    input  logic [ROW_W-1:0]               i_row,
    input  logic [IDX_W-1:0]               i_idx,
    input  logic [drat_pkg::WORD_W-1:0]    i_wdata,
    input  logic                           i_cfg_valid,
    input  logic [drat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drat_pkg::DLY_W-1:0]     i_cfg_data,
    output logic                           o_clearing,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output drat_pkg::t_out_item            o_out_item
);
    import drat_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    t_back_state r_state, n_state;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [IDX_W-1:0]      r_clr_addr;

    logic [DLY_W-1:0]   r_row_dly, r_col_dly;
    logic [ROW_W-1:0]   r_open_row, n_open_row;
    logic               r_open_vld, n_open_vld;
    logic [TOTAL_W-1:0] r_total, n_total;

    logic               r_b_vld;
    logic               r_b_read;
    logic               r_b_hit;
    logic [COST_W-1:0]  r_b_cost;
    logic [TOTAL_W-1:0] r_b_total;
    logic               r_o_vld;
    t_out_item          r_o_item;

    logic                  adv_o;
    logic                  go;
    logic                  hit;
    logic                  is_access;
    logic [COST_W-1:0]     row_c, col_c, cost;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;

    // Next state: sweep the store once after reset, then run
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_addr == LAST_IDX) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN:  n_state = BK_RUN;
            default: n_state = BK_CLEAR;
        endcase
    end

    // State outputs: memory write port and issue control
    always_comb begin
        o_clearing = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = i_idx;
        mem_wdata  = DATA_WIDTH'(i_wdata);
        go         = 1'b0;
        adv_o      = !r_o_vld || !i_out_stall;
        case (r_state)
            BK_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
            end
            BK_RUN: begin
                go     = !i_empty && (!r_b_vld || adv_o);
                mem_we = go && (i_op == OP_WRITE);
            end
            default: o_clearing = 1'b1;
        endcase
        o_pop = go;
    end

    // Classify against the open row and price the request
    always_comb begin
        row_c      = COST_W'(r_row_dly);
        col_c      = COST_W'(r_col_dly);
        hit        = r_open_vld && (r_open_row == i_row);
        is_access  = 1'b0;
        cost       = '0;
        n_open_row = r_open_row;
        n_open_vld = r_open_vld;
        case (i_op)
            OP_READ, OP_WRITE: begin
                is_access  = 1'b1;
                n_open_row = i_row;
                n_open_vld = 1'b1;
                if (hit) begin
                    cost = col_c;
                end else begin
                    cost = (r_open_vld ? row_c : '0) + row_c + col_c;
                end
            end
            OP_FLUSH: begin
                n_open_vld = 1'b0;
                cost       = r_open_vld ? row_c : '0;
            end
            default: cost = '0;
        endcase
        n_total = r_total + TOTAL_W'(cost);
    end

    // Sweep counter and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Delay registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_dly <= ROW_DLY_RESET;
            r_col_dly <= COL_DLY_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROW_DELAY: r_row_dly <= i_cfg_data;
                CFG_COL_DELAY: r_col_dly <= i_cfg_data;
                default:       r_row_dly <= r_row_dly;
            endcase
        end
    end

    // Open-row tag and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_row <= '0;
            r_open_vld <= 1'b0;
            r_total    <= '0;
        end else if (go) begin
            r_open_row <= n_open_row;
            r_open_vld <= n_open_vld;
            r_total    <= n_total;
        end
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (go) begin
            r_rdata <= r_mem[i_idx];
        end
    end

    // Access stage and output register valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (go) begin
                r_b_vld <= 1'b1;
            end else if (adv_o) begin
                r_b_vld <= 1'b0;
            end
            if (adv_o) begin
                r_o_vld <= r_b_vld;
            end
        end
    end

    // Access stage and output register payloads
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b_read  <= (i_op == OP_READ);
            r_b_hit   <= hit && is_access;
            r_b_cost  <= cost;
            r_b_total <= n_total;
        end
        if (adv_o && r_b_vld) begin
            r_o_item.read_data     <= r_b_read ? WORD_W'(r_rdata) : '0;
            r_o_item.row_hit       <= r_b_hit;
            r_o_item.access_cycles <= r_b_cost;
            r_o_item.total_cycles  <= r_b_total;
        end
    end

    always_comb begin
        o_out_valid = r_o_vld;
        o_out_item  = r_o_item;
    end

endmodule

[rtl/core/dram_open_row_access_timer_unit.sv]
`timescale 1ns / 1ps
// DRAM bank timing model with one open-row buffer.
// Request channel: i_in_valid / o_in_stall with i_in_item (operation, address,
// write_data). A request is taken at a clock edge where valid is high and stall low.
// Result channel: o_out_valid / i_out_stall with o_out_item (read_data, row_hit,
// access_cycles, total_cycles); exactly one result per request, in request order.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index (0 row delay,
// 1 column delay) and i_cfg_data; ready is always high. Write only while idle.
// Path from request to result: the front stages, the queue, the access stage and
// the output register. Throughput: one request per cycle while no stall or reset
// sweep holds it; each request reads the store once, and a write also writes it.
// A 3-stage front splits the address, a 4-entry queue decouples it from the back.
// Reset: the store is swept to zero one word per cycle over ROWS*COLUMNS words
// (capped at 2^20 reachable words, 1048576 by default); o_in_stall is high for the
// whole sweep. Delays return to 10 and 2, no row is open, total is zero.
// Result stall: the output register holds, the back end and queue fill, and
// o_in_stall rises once the front pipe backs up.
module dram_open_row_access_timer_unit #(
    parameter int unsigned ROWS        = 1024,
    parameter int unsigned COLUMNS     = 1024,
    parameter int unsigned DATA_WIDTH  = 32,
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  drat_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output drat_pkg::t_out_item            o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [drat_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drat_pkg::DLY_W-1:0]     i_cfg_data
);
    import drat_pkg::*;

    localparam longint unsigned CELLS = longint'(ROWS) * longint'(COLUMNS);
    localparam longint unsigned SPAN  = 64'd1 << ADDR_W;
    localparam int unsigned DEPTH     = (CELLS > SPAN) ? int'(SPAN) : int'(CELLS);
    localparam int unsigned ROW_W     = $clog2(ROWS);
    localparam int unsigned IDX_W     = $clog2(DEPTH);
    localparam int unsigned Q_WIDTH   = OP_W + ROW_W + IDX_W + WORD_W;

    logic               push, pop, full, empty, clearing;
    logic [OP_W-1:0]    f_op, b_op;
    logic [ROW_W-1:0]   f_row, b_row;
    logic [IDX_W-1:0]   f_idx, b_idx;
    logic [WORD_W-1:0]  f_wdata, b_wdata;
    logic [Q_WIDTH-1:0] q_in, q_out;

    assign o_cfg_ready = 1'b1;

    // Pack and unpack queue entries
    assign q_in = {f_op, f_row, f_idx, f_wdata};
    assign {b_op, b_row, b_idx, b_wdata} = q_out;

    drat_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .ROW_W   (ROW_W),
        .IDX_W   (IDX_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_hold     (clearing),
        .o_push     (push),
        .i_full     (full),
        .o_op       (f_op),
        .o_row      (f_row),
        .o_idx      (f_idx),
        .o_wdata    (f_wdata)
    );

    drat_fifo #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    drat_back #(
        .ROW_W      (ROW_W),
        .IDX_W      (IDX_W),
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_op        (b_op),
        .i_row       (b_row),
        .i_idx       (b_idx),
        .i_wdata     (b_wdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

[rtl/core/drat_checker.sv]
`timescale 1ns / 1ps
`include "dram_open_row_access_timer_unit_assert.svh"
module drat_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input drat_pkg::t_out_item o_out_item
);
    import drat_pkg::*;

    localparam logic [COST_W-1:0] COST_MAX = COST_W'(3 * ((1 << DLY_W) - 1));

    logic [TOTAL_W-1:0] r_last_total;
    logic [TOTAL_W-1:0] exp_total;
    logic               out_xfer;

    assign out_xfer  = o_out_valid && !i_out_stall;
    assign exp_total = r_last_total + TOTAL_W'(o_out_item.access_cycles);

    // Track the total of the last transferred result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_total <= '0;
        end else if (out_xfer) begin
            r_last_total <= o_out_item.total_cycles;
        end
    end

    `DRAT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "drat: stalled result changed")
    `DRAT_ASSERT_NOW(a_total_sum, o_out_valid, o_out_item.total_cycles == exp_total, "drat: running total does not add up")
    `DRAT_ASSERT_NOW(a_cost_max, o_out_valid, o_out_item.access_cycles <= COST_MAX, "drat: access cost out of range")
    `DRAT_ASSERT_NOW(a_reset_quiet, $rose(i_rst_n), o_in_stall && !o_out_valid, "drat: not quiet after reset")

endmodule

bind dram_open_row_access_timer_unit drat_checker u_drat_checker (.*);
